// ===== design/sha_pkg.sv =====
// Package: SHA-256 types, constants and round functions.
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam logic [7:0]  PadByte    = 8'h80;
    localparam logic [5:0]  LenPos     = 6'd56;

    localparam logic CmdAbsorb = 1'b0;
    localparam logic CmdDigest = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef logic [31:0] t_word;
    typedef t_word [7:0] t_hash;

    // Control from sequencer to the compression core.
    typedef struct packed {
        logic start;
        logic busy;
    } t_core_ctl;

    function automatic t_word init_hash(input logic [2:0] i);
        unique case (i)
            3'd0: init_hash = 32'h6a09e667;
            3'd1: init_hash = 32'hbb67ae85;
            3'd2: init_hash = 32'h3c6ef372;
            3'd3: init_hash = 32'ha54ff53a;
            3'd4: init_hash = 32'h510e527f;
            3'd5: init_hash = 32'h9b05688c;
            3'd6: init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic t_word round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        round_k = k[i];
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== design/sha_core.sv =====
// One-round-per-cycle SHA-256 compression core with rolling schedule window.
module sha_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha_pkg::t_core_ctl  i_ctl,
    input  sha_pkg::t_hash      i_hash,
    input  logic [511:0]        i_block,
    output sha_pkg::t_hash      o_hash,
    output logic                o_done
);
    import sha_pkg::*;

    logic [5:0]  r_round;
    logic        r_run;
    t_word       r_w [16];
    t_hash       r_v;
    t_hash       r_h;
    t_word       n_w;
    t_word       t1, t2, e, a, p, q;

    assign e = r_v[4];
    assign a = r_v[0];
    assign p = r_w[1];
    assign q = r_w[14];
    assign n_w = r_w[0] + (rotr(p, 7) ^ rotr(p, 18) ^ (p >> 3)) + r_w[9]
               + (rotr(q, 17) ^ rotr(q, 19) ^ (q >> 10));
    assign t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + round_k(r_round) + r_w[0];
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_round <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_ctl.start && !r_run) begin
                r_run   <= 1'b1;
                r_round <= '0;
            end else if (r_run) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'(Rounds - 1)) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_run) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_block[511 - 32*i -: 32];
            end
            r_v <= i_hash;
            r_h <= i_hash;
        end else if (r_run) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= n_w;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= e;
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= a;
            r_v[0] <= t1 + t2;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_hash[i] = r_h[i] + r_v[i];
        end
    end
endmodule

// ===== design/sha256_stream_hasher.sv =====
// Top level: SHA-256 stream hasher with byte intake, padding and digest output.
// Absorb: one byte per cycle while idle; the 64th byte of a block starts a
//   compression (one round a cycle in the shared core), and ready returns after it.
// Digest: compression of one or two padded blocks, then eight output transfers,
//   one per cycle while i_ready stays high.
// Reset (synchronous, active low): chain value to the initial hash, counts
//   to zero; block buffer contents are left undefined.
module sha256_stream_hasher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sha_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output sha_pkg::t_out_item o_data
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ABS, ST_PAD1, ST_PAD2, ST_OUT
    } t_state;

    t_state        r_state;
    t_hash         r_chain;
    t_hash         r_dig;
    logic [511:0]  r_buf;       // live message block
    logic [511:0]  r_blk;       // block handed to the core
    logic [5:0]    r_fill;
    logic [63:0]   r_bits;
    logic [2:0]    r_idx;
    logic          r_start;
    t_core_ctl     core_ctl;
    t_hash         core_hash;
    logic          core_done;
    logic [511:0]  pad_blk;
    logic [511:0]  len_blk;

    assign core_ctl.start = r_start;
    assign core_ctl.busy  = (r_state != ST_IDLE) && (r_state != ST_OUT);

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_hash  ((r_state == ST_PAD2) ? r_dig : r_chain),
        .i_block (r_blk),
        .o_hash  (core_hash),
        .o_done  (core_done)
    );

    // Padding: keep bytes below fill, 0x80 at fill, zeros above; length
    // lands in the last 8 bytes when fill leaves room.
    always_comb begin
        pad_blk = r_buf;
        for (int i = 0; i < BlockBytes; i++) begin
            if (6'(i) == r_fill) begin
                pad_blk[511 - 8*i -: 8] = PadByte;
            end else if (6'(i) > r_fill) begin
                pad_blk[511 - 8*i -: 8] = 8'h00;
            end
        end
        len_blk = {448'd0, r_bits};
        if (r_fill < LenPos) begin
            pad_blk[63:0] = r_bits;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_data.digest_word = r_dig[r_idx];
    assign o_data.word_index  = r_idx;
    assign o_data.last_word   = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
            r_idx   <= '0;
            r_start <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= init_hash(3'(i));
            end
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        if (i_data.cmd == CmdAbsorb) begin
                            r_buf[511 - {r_fill, 3'b000} -: 8] <= i_data.data_byte;
                            r_bits <= r_bits + 64'd8;
                            r_fill <= r_fill + 6'd1;
                            if (r_fill == 6'(BlockBytes - 1)) begin
                                r_blk   <= {r_buf[511:8], i_data.data_byte};
                                r_start <= 1'b1;
                                r_state <= ST_ABS;
                            end
                        end else begin
                            r_blk   <= pad_blk;
                            r_start <= 1'b1;
                            r_state <= ST_PAD1;
                        end
                    end
                end
                ST_ABS: begin
                    if (core_done) begin
                        r_chain <= core_hash;
                        r_state <= ST_IDLE;
                    end
                end
                ST_PAD1: begin
                    if (core_done) begin
                        r_dig <= core_hash;
                        r_idx <= '0;
                        if (r_fill >= LenPos) begin
                            r_blk   <= len_blk;
                            r_start <= 1'b1;
                            r_state <= ST_PAD2;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_PAD2: begin
                    if (core_done) begin
                        r_dig   <= core_hash;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // No new item is taken while the core compresses.
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_ctl.busy |-> !o_ready) else $error("ready while busy");
    // Digest words go out in order, wrapping after the last.
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_data.last_word) |=> (o_valid && r_idx == $past(r_idx) + 3'd1))
        else $error("index skip");
    // A core start is only raised while in a busy state.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> core_ctl.busy) else $error("start while idle");
endmodule

// ===== verif/tb_sha256_stream_hasher.sv =====
// Testbench for sha256_stream_hasher: byte stream in, digest words checked against a hash model.
`timescale 1ns / 100ps

module tb_sha256_stream_hasher;
    import sha_pkg::*;

    // Hash model plus queue of digest words still owed by the block.
    class digest_scoreboard;
        logic [31:0] chain [8];
        logic [7:0]  blk [64];
        logic [5:0]  fill;
        logic [63:0] bit_len;
        t_out_item   owed [$];
        int          errors;

        function void clear();
            logic [31:0] iv [8];
            iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
            chain = iv;
            fill = 0;
            bit_len = 0;
            errors = 0;
            owed.delete();
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress(ref logic [31:0] h [8], input logic [7:0] b [64]);
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2, e, a;
            logic [31:0] kc [64];
            kc = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
            for (int i = 0; i < 16; i++)
                w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = w[i-16] + w[i-7]
                     + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                     + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
            v = h;
            for (int i = 0; i < 64; i++) begin
                e = v[4];
                a = v[0];
                t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
                   + ((e & v[5]) ^ (~e & v[6])) + kc[i] + w[i];
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
                   + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = e; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = a; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
        endfunction

        // Absorb updates the running state; digest pads a copy and queues 8 words.
        function void note_transfer(t_in_item it);
            logic [31:0] h [8];
            logic [7:0]  pb [64];
            t_out_item   r;
            if (it.cmd == CmdAbsorb) begin
                blk[fill] = it.data_byte;
                bit_len = bit_len + 64'd8;
                fill = fill + 6'd1;
                if (fill == 0) compress(chain, blk);
            end else begin
                h = chain;
                pb = blk;
                pb[fill] = PadByte;
                for (int i = fill + 1; i < 64; i++) pb[i] = 8'h00;
                if (fill >= LenPos) begin
                    compress(h, pb);
                    for (int i = 0; i < 64; i++) pb[i] = 8'h00;
                end
                for (int i = 0; i < 8; i++) pb[56+i] = bit_len[63-8*i -: 8];
                compress(h, pb);
                for (int i = 0; i < 8; i++) begin
                    r.digest_word = h[i];
                    r.word_index = i[2:0];
                    r.last_word = (i == 7);
                    owed.push_back(r);
                end
            end
        endfunction

        function void check_word(t_out_item got);
            t_out_item want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected digest word expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.digest_word !== want.digest_word) begin
                $display("%0t: digest_word expected %h actual %h", $time,
                         want.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== want.word_index) begin
                $display("%0t: word_index expected %0d actual %0d", $time,
                         want.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== want.last_word) begin
                $display("%0t: last_word expected %b actual %b", $time,
                         want.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in_item   i_data = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out_item  o_data;

    digest_scoreboard sb = new();
    int  cycle_count = 0;
    bit  idle_on = 1'b1;     // random bursts of idling allowed
    bit  sink_hold = 1'b0;   // long receiver hold-off requested

    always #2 i_clk = ~i_clk;

    sha256_stream_hasher DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    // Monitors: sample both handshakes at the edge, before driven updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note_transfer(i_data);
        if (i_rst_n && o_valid && i_ready) sb.check_word(o_data);
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb_sha256_stream_hasher failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin : sink
        int n;
        @(posedge i_clk);
        forever begin
            if (sink_hold) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                sink_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 17);
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one item and hold it until the transfer happens.
    task automatic send_item(input logic cmd, input logic [7:0] b);
        int n;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{cmd: cmd, data_byte: b};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stim
        int len;
        sb.clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message digest (data ignored), byte extremes,
        // fill of 55/56 (one vs two padded blocks), full block boundary.
        send_item(CmdDigest, 8'hFF);
        send_item(CmdAbsorb, 8'h00);
        send_item(CmdAbsorb, 8'hFF);
        send_item(CmdDigest, 8'h00);
        send_item(CmdDigest, 8'hA5);
        for (int i = 2; i < 55; i++) send_item(CmdAbsorb, 8'(i * 37));
        send_item(CmdDigest, 8'h00);
        send_item(CmdAbsorb, 8'h5A);
        send_item(CmdDigest, 8'h00);
        for (int i = 56; i < 64; i++) send_item(CmdAbsorb, 8'(~i));
        send_item(CmdDigest, 8'h00);

        // Pressure: stall the receiver long while further digest requests wait for ready.
        drain();
        sink_hold = 1'b1;
        for (int i = 0; i < 4; i++) send_item(CmdDigest, 8'(i));
        drain();

        // Random messages: runs of absorbs ending in a digest, some noise.
        for (int m = 0; m < 12; m++) begin
            if (m == 9) idle_on = 1'b0;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 70)
                                              : $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
                send_item(CmdAbsorb, 8'($urandom_range(0, 255)));
            send_item(CmdDigest, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0) send_item(CmdDigest, 8'($urandom));
        end
        i_valid <= 1'b0;
        drain();
        repeat (200) @(posedge i_clk);

        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("tb_sha256_stream_hasher passed");
        end else begin
            $display("tb_sha256_stream_hasher failed");
        end
        $finish;
    end
endmodule

// ===== sha256_stream_hasher.f =====
design/sha_pkg.sv
design/sha_core.sv
design/sha256_stream_hasher.sv
verif/tb_sha256_stream_hasher.sv
